/* src/cwh_pkg.sv */
// cwh_pkg: shared types, sizes and arithmetic helpers for the hermite interpolator
// depends on nothing; imported by clamped_walk_hermite_interpolator_top and its testbench
package cwh_pkg;

    localparam int KNOT_DEPTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int AW  = $clog2(KNOT_DEPTH);
    localparam int CW  = $clog2(KNOT_DEPTH + 1);
    // dividend magnitude: 33-bit difference shifted up by the fraction
    localparam int DW  = 33 + FRAC_BITS;
    localparam int DWC = $clog2(DW + 1);
    localparam int DVW = 34;
    localparam int MW  = 34;
    localparam int PW  = 2 * MW;
    localparam int ACW = 52;
    localparam int UW  = FRAC_BITS + 1;
    localparam int HW  = UW + 3;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_RANGE       = 2'd1,
        ST_BAD_STEP    = 2'd2,
        ST_NOT_STARTED = 2'd3
    } status_t;

    localparam logic [1:0] CFG_VALUE_MIN = 2'd0;
    localparam logic [1:0] CFG_VALUE_MAX = 2'd1;

    typedef struct packed {
        logic signed [31:0] knot_time;
        logic signed [31:0] knot_value;
        logic signed [31:0] knot_slope;
    } knot_t;

    // ring position of the k-th knot counted from the oldest
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [AW-1:0] k);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, k};
        if (s >= (AW+1)'(KNOT_DEPTH))
        begin
            s = s - (AW+1)'(KNOT_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACW-1:0] v);
        logic same;
        same = (&v[ACW-1:31]) || !(|v[ACW-1:31]);
        if (same)
        begin
            return v[31:0];
        end
        return v[ACW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // divide a product by the unit, truncating toward zero
    function automatic logic signed [PW-1:0] unit_scale(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] b;
        b = p + $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{p[PW-1]}}});
        return b >>> FRAC_BITS;
    endfunction

endpackage

/* src/clamped_walk_hermite_interpolator_top.sv */
// clamped_walk_hermite_interpolator_top: one channel of the knot ring and hermite evaluator
// depends on cwh_pkg; holds the knot memory, the serial divider and the shared multiplier
//
// One word in, one word out. Knots live in a single synchronous memory (one read, one write
// per cycle, registered read data), so every access is a step of the sequencer. A start
// writes the two first knots. An append reads the last two knots, checks the step, runs two
// divisions on the one-bit-per-cycle divider and does two write-backs. A query reads the
// first, last and second-to-last knots, walks back one knot per search step to find the
// segment, reads its end knot, then runs one division and eight multiplies on the shared
// multiplier. A new word is taken once the previous result sits in the output register,
// even while that result is still stalled.
module clamped_walk_hermite_interpolator_top
    import cwh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [31:0] start_value,
    input  logic [30:0]        time_step,
    input  logic signed [31:0] value_change,
    input  logic signed [31:0] query_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [1:0]         status,
    output logic               needs_more
);

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_ST_W0   = 24'h000002,
        S_ST_W1   = 24'h000004,
        S_AP_RA   = 24'h000008,
        S_AP_RB   = 24'h000010,
        S_AP_CB   = 24'h000020,
        S_AP_CALC = 24'h000040,
        S_DIV_A   = 24'h000080,
        S_DIV_B   = 24'h000100,
        S_AP_WB   = 24'h000200,
        S_AP_WN   = 24'h000400,
        S_Q_R0    = 24'h000800,
        S_Q_R1    = 24'h001000,
        S_Q_R2    = 24'h002000,
        S_Q_CHK   = 24'h004000,
        S_Q_SR    = 24'h008000,
        S_Q_SC    = 24'h010000,
        S_Q_RB    = 24'h020000,
        S_Q_CB    = 24'h040000,
        S_Q_CALC  = 24'h080000,
        S_DIV_U   = 24'h100000,
        S_MUL     = 24'h200000,
        S_Q_SAT   = 24'h400000,
        S_FIN     = 24'h800000
    } state_t;

    // knot memory
    knot_t knot_mem [KNOT_DEPTH];
    knot_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    knot_t         wr_data;

    // control registers
    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic signed [31:0] vmin_reg, vmin_next, vmax_reg, vmax_next;
    logic [DWC-1:0] div_cnt_reg, div_cnt_next;
    logic [2:0]    mstep_reg, mstep_next;
    logic          mphase_reg, mphase_next;
    logic          out_valid_reg, out_valid_next;

    // datapath registers
    logic signed [31:0] sv_reg, sv_next;
    logic [30:0]        step_reg, step_next;
    logic signed [31:0] chg_reg, chg_next, q_reg, q_next;
    logic signed [31:0] ta_reg, ta_next, va_reg, va_next, sa_reg, sa_next;
    logic signed [31:0] tb_reg, tb_next, vb_reg, vb_next, sb_reg, sb_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic signed [31:0] nt_reg, nt_next, nv_reg, nv_next, slope_reg, slope_next;
    logic signed [DW:0] chord_reg, chord_next;
    logic [32:0]        dt_reg, dt_next;
    logic [DVW-1:0]     div_rem_reg, div_rem_next, div_den_reg, div_den_next;
    logic [DW-1:0]      div_quo_reg, div_quo_next;
    logic               div_neg_reg, div_neg_next;
    logic [UW-1:0]      u_reg, u_next, u2_reg, u2_next, u3_reg, u3_next;
    logic signed [MW-1:0]  tmp_reg, tmp_next;
    logic signed [ACW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0]  p_reg, p_next;
    logic signed [31:0] res_reg, res_next;
    status_t            rstat_reg, rstat_next;
    logic               rmore_reg, rmore_next;
    logic signed [31:0] out_val_reg, out_val_next;
    status_t            out_stat_reg, out_stat_next;
    logic               out_more_reg, out_more_next;

    // combinational helpers
    logic [AW-1:0]      cm1, cm2;
    logic               accept;
    logic [DVW:0]       rem_sh, rem_diff;
    logic               rem_ge;
    logic signed [DW:0] q_signed;
    logic signed [32:0] nt_w, nv_s, nv_c, vmin33, vmax33, tdiff;
    logic signed [33:0] dv, dv_abs;
    logic signed [DW+1:0] slope_sum;
    logic signed [HW-1:0] u1s, u2s, u3s, h00, h10, h01, h11;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] p_scaled;

    assign cm1       = AW'(count_reg - CW'(1));
    assign cm2       = AW'(count_reg - CW'(2));
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign result_value = out_val_reg;
    assign status       = out_stat_reg;
    assign needs_more   = out_more_reg;

    // restoring divider step
    assign rem_sh   = {div_rem_reg, div_quo_reg[DW-1]};
    assign rem_diff = rem_sh - {1'b0, div_den_reg};
    assign rem_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign q_signed = div_neg_reg ? -$signed({1'b0, div_quo_reg}) : $signed({1'b0, div_quo_reg});

    // hermite bases
    assign u1s = $signed({3'b000, u_reg});
    assign u2s = $signed({3'b000, u2_reg});
    assign u3s = $signed({3'b000, u3_reg});
    assign h00 = (u3s <<< 1) - (u2s + (u2s <<< 1)) + $signed(HW'(1) << FRAC_BITS);
    assign h10 = u3s - (u2s <<< 1) + u1s;
    assign h01 = (u2s + (u2s <<< 1)) - (u3s <<< 1);
    assign h11 = u3s - u2s;

    assign p_scaled = unit_scale(p_reg);

    always_comb
    begin
        case (mstep_reg)
            3'd0:
            begin
                mul_a = $signed(MW'(u_reg));
                mul_b = $signed(MW'(u_reg));
            end
            3'd1:
            begin
                mul_a = $signed(MW'(u2_reg));
                mul_b = $signed(MW'(u_reg));
            end
            3'd2:
            begin
                mul_a = MW'(h00);
                mul_b = MW'(va_reg);
            end
            3'd3:
            begin
                mul_a = MW'(h10);
                mul_b = MW'(sa_reg);
            end
            3'd5:
            begin
                mul_a = MW'(h01);
                mul_b = MW'(vb_reg);
            end
            3'd6:
            begin
                mul_a = MW'(h11);
                mul_b = MW'(sb_reg);
            end
            default:
            begin
                mul_a = tmp_reg;
                mul_b = $signed({1'b0, dt_reg});
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_AP_RA: rd_addr = slot(head_reg, cm2);
            S_AP_RB: rd_addr = slot(head_reg, cm1);
            S_Q_R0:  rd_addr = slot(head_reg, AW'(0));
            S_Q_R1:  rd_addr = slot(head_reg, cm1);
            S_Q_R2:  rd_addr = slot(head_reg, cm2);
            S_Q_SR:  rd_addr = slot(head_reg, idx_reg);
            S_Q_RB:  rd_addr = slot(head_reg, AW'(idx_reg + AW'(1)));
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        vmin_next      = vmin_reg;
        vmax_next      = vmax_reg;
        div_cnt_next   = div_cnt_reg;
        mstep_next     = mstep_reg;
        mphase_next    = mphase_reg;
        out_valid_next = out_valid_reg;
        sv_next        = sv_reg;
        step_next      = step_reg;
        chg_next       = chg_reg;
        q_next         = q_reg;
        ta_next        = ta_reg;
        va_next        = va_reg;
        sa_next        = sa_reg;
        tb_next        = tb_reg;
        vb_next        = vb_reg;
        sb_next        = sb_reg;
        idx_next       = idx_reg;
        nt_next        = nt_reg;
        nv_next        = nv_reg;
        slope_next     = slope_reg;
        chord_next     = chord_reg;
        dt_next        = dt_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_quo_next   = div_quo_reg;
        div_neg_next   = div_neg_reg;
        u_next         = u_reg;
        u2_next        = u2_reg;
        u3_next        = u3_reg;
        tmp_next       = tmp_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        res_next       = res_reg;
        rstat_next     = rstat_reg;
        rmore_next     = rmore_reg;
        out_val_next   = out_val_reg;
        out_stat_next  = out_stat_reg;
        out_more_next  = out_more_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        nt_w           = '0;
        nv_s           = '0;
        nv_c           = '0;
        vmin33         = $signed({vmin_reg[31], vmin_reg});
        vmax33         = $signed({vmax_reg[31], vmax_reg});
        tdiff          = '0;
        dv             = '0;
        dv_abs         = '0;
        slope_sum      = '0;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_VALUE_MIN)
            begin
                vmin_next = cfg_data;
            end
            else if (cfg_index == CFG_VALUE_MAX)
            begin
                vmax_next = cfg_data;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // serial divider runs in any divide state until the count is spent
        if ((state_reg == S_DIV_A || state_reg == S_DIV_B || state_reg == S_DIV_U)
            && div_cnt_reg != '0)
        begin
            div_cnt_next = div_cnt_reg - DWC'(1);
            div_rem_next = rem_ge ? rem_diff[DVW-1:0] : rem_sh[DVW-1:0];
            div_quo_next = {div_quo_reg[DW-2:0], rem_ge};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sv_next    = start_value;
                    step_next  = time_step;
                    chg_next   = value_change;
                    q_next     = query_time;
                    res_next   = '0;
                    rstat_next = ST_OK;
                    rmore_next = 1'b0;
                    case (op_t'(op))
                        OP_START:
                        begin
                            state_next = S_ST_W0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                rstat_next = ST_NOT_STARTED;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_AP_RA;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                rstat_next = ST_NOT_STARTED;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_Q_R0;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_ST_W0:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{-(32'sd1 <<< FRAC_BITS), sv_reg, 32'sd0};
                state_next = S_ST_W1;
            end
            S_ST_W1:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(1);
                wr_data    = '{-(32'sd1 <<< (FRAC_BITS - 1)), sv_reg, 32'sd0};
                head_next  = '0;
                count_next = CW'(2);
                state_next = S_FIN;
            end
            S_AP_RA:
            begin
                state_next = S_AP_RB;
            end
            S_AP_RB:
            begin
                ta_next    = rd_data_reg.knot_time;
                va_next    = rd_data_reg.knot_value;
                state_next = S_AP_CB;
            end
            S_AP_CB:
            begin
                tb_next    = rd_data_reg.knot_time;
                vb_next    = rd_data_reg.knot_value;
                state_next = S_AP_CALC;
            end
            S_AP_CALC:
            begin
                nt_w = $signed({tb_reg[31], tb_reg}) + $signed({2'b00, step_reg});
                nv_s = $signed({vb_reg[31], vb_reg}) + $signed({chg_reg[31], chg_reg});
                nv_c = (nv_s > vmax33) ? vmax33 : nv_s;
                nv_c = (nv_c < vmin33) ? vmin33 : nv_c;
                dv   = $signed({nv_c[32], nv_c}) - $signed({{2{vb_reg[31]}}, vb_reg});
                dv_abs = dv[33] ? -dv : dv;
                // the step must be nonzero and the new time must stay at or below the largest positive time
                if (step_reg == '0 || (!nt_w[32] && nt_w[31]))
                begin
                    rstat_next = ST_BAD_STEP;
                    state_next = S_FIN;
                end
                else
                begin
                    nt_next      = nt_w[31:0];
                    nv_next      = nv_c[31:0];
                    div_rem_next = '0;
                    div_quo_next = {dv_abs[32:0], {FRAC_BITS{1'b0}}};
                    div_den_next = DVW'({step_reg, 1'b0});
                    div_neg_next = dv[33];
                    div_cnt_next = DWC'(DW);
                    state_next   = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                if (div_cnt_reg == '0)
                begin
                    tdiff        = $signed({tb_reg[31], tb_reg}) - $signed({ta_reg[31], ta_reg});
                    dv           = $signed({{2{vb_reg[31]}}, vb_reg})
                                 - $signed({{2{va_reg[31]}}, va_reg});
                    dv_abs       = dv[33] ? -dv : dv;
                    chord_next   = q_signed;
                    div_rem_next = '0;
                    div_quo_next = {dv_abs[32:0], {FRAC_BITS{1'b0}}};
                    div_den_next = {tdiff[32:0], 1'b0};
                    div_neg_next = dv[33];
                    div_cnt_next = DWC'(DW);
                    state_next   = S_DIV_B;
                end
            end
            S_DIV_B:
            begin
                if (div_cnt_reg == '0)
                begin
                    slope_sum  = $signed({chord_reg[DW], chord_reg})
                               + $signed({q_signed[DW], q_signed});
                    slope_next = sat32(ACW'(slope_sum));
                    state_next = S_AP_WB;
                end
            end
            S_AP_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot(head_reg, cm1);
                wr_data    = '{tb_reg, vb_reg, slope_reg};
                state_next = S_AP_WN;
            end
            S_AP_WN:
            begin
                wr_en   = 1'b1;
                wr_data = '{nt_reg, nv_reg, 32'sd0};
                if (count_reg < CW'(KNOT_DEPTH))
                begin
                    wr_addr    = slot(head_reg, AW'(count_reg));
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    // ring full: overwrite the oldest knot
                    wr_addr   = head_reg;
                    head_next = slot(head_reg, AW'(1));
                end
                state_next = S_FIN;
            end
            S_Q_R0:
            begin
                state_next = S_Q_R1;
            end
            S_Q_R1:
            begin
                ta_next    = rd_data_reg.knot_time;
                state_next = S_Q_R2;
            end
            S_Q_R2:
            begin
                tb_next    = rd_data_reg.knot_time;
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                rmore_next = (rd_data_reg.knot_time < q_reg);
                if (!(ta_reg < q_reg && q_reg < tb_reg))
                begin
                    rstat_next = ST_RANGE;
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = cm2;
                    state_next = S_Q_SR;
                end
            end
            S_Q_SR:
            begin
                state_next = S_Q_SC;
            end
            S_Q_SC:
            begin
                if (idx_reg != '0 && rd_data_reg.knot_time > q_reg)
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_Q_SR;
                end
                else
                begin
                    ta_next    = rd_data_reg.knot_time;
                    va_next    = rd_data_reg.knot_value;
                    sa_next    = rd_data_reg.knot_slope;
                    state_next = S_Q_RB;
                end
            end
            S_Q_RB:
            begin
                state_next = S_Q_CB;
            end
            S_Q_CB:
            begin
                tb_next    = rd_data_reg.knot_time;
                vb_next    = rd_data_reg.knot_value;
                sb_next    = rd_data_reg.knot_slope;
                state_next = S_Q_CALC;
            end
            S_Q_CALC:
            begin
                tdiff = $signed({tb_reg[31], tb_reg}) - $signed({ta_reg[31], ta_reg});
                if (tdiff <= 33'sd0)
                begin
                    tdiff = 33'sd1;
                end
                nv_s         = $signed({q_reg[31], q_reg}) - $signed({ta_reg[31], ta_reg});
                dt_next      = tdiff[32:0];
                acc_next     = '0;
                div_rem_next = '0;
                div_quo_next = {nv_s[32:0], {FRAC_BITS{1'b0}}};
                div_den_next = DVW'(tdiff[32:0]);
                div_neg_next = 1'b0;
                div_cnt_next = DWC'(DW);
                state_next   = S_DIV_U;
            end
            S_DIV_U:
            begin
                if (div_cnt_reg == '0)
                begin
                    u_next      = q_signed[UW-1:0];
                    mstep_next  = '0;
                    mphase_next = 1'b0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                if (!mphase_reg)
                begin
                    p_next      = mul_a * mul_b;
                    mphase_next = 1'b1;
                end
                else
                begin
                    mphase_next = 1'b0;
                    mstep_next  = mstep_reg + 3'd1;
                    case (mstep_reg)
                        3'd0:    u2_next  = p_scaled[UW-1:0];
                        3'd1:    u3_next  = p_scaled[UW-1:0];
                        3'd3:    tmp_next = p_scaled[MW-1:0];
                        3'd6:    tmp_next = p_scaled[MW-1:0];
                        default: acc_next = acc_reg + p_scaled[ACW-1:0];
                    endcase
                    if (mstep_reg == 3'd7)
                    begin
                        state_next = S_Q_SAT;
                    end
                end
            end
            S_Q_SAT:
            begin
                res_next   = sat32(acc_reg);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_reg;
                    out_stat_next  = rstat_reg;
                    out_more_next  = rmore_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            vmin_reg      <= 32'sd0;
            vmax_reg      <= 32'sd1 <<< FRAC_BITS;
            div_cnt_reg   <= '0;
            mstep_reg     <= '0;
            mphase_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            vmin_reg      <= vmin_next;
            vmax_reg      <= vmax_next;
            div_cnt_reg   <= div_cnt_next;
            mstep_reg     <= mstep_next;
            mphase_reg    <= mphase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sv_reg       <= sv_next;
        step_reg     <= step_next;
        chg_reg      <= chg_next;
        q_reg        <= q_next;
        ta_reg       <= ta_next;
        va_reg       <= va_next;
        sa_reg       <= sa_next;
        tb_reg       <= tb_next;
        vb_reg       <= vb_next;
        sb_reg       <= sb_next;
        idx_reg      <= idx_next;
        nt_reg       <= nt_next;
        nv_reg       <= nv_next;
        slope_reg    <= slope_next;
        chord_reg    <= chord_next;
        dt_reg       <= dt_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        div_quo_reg  <= div_quo_next;
        div_neg_reg  <= div_neg_next;
        u_reg        <= u_next;
        u2_reg       <= u2_next;
        u3_reg       <= u3_next;
        tmp_reg      <= tmp_next;
        acc_reg      <= acc_next;
        p_reg        <= p_next;
        res_reg      <= res_next;
        rstat_reg    <= rstat_next;
        rmore_reg    <= rmore_next;
        out_val_reg  <= out_val_next;
        out_stat_reg <= out_stat_next;
        out_more_reg <= out_more_next;
    end

    // reads are issued only before the write-backs of the same word, so no forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            knot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= knot_mem[rd_addr];
    end

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(KNOT_DEPTH)) && (count_reg != CW'(1)))
        else $error("knot count out of range");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != S_IDLE) && (state_reg != S_FIN))
        else $error("knot write outside a start or append");

    a_search_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_RB) |-> ({1'b0, idx_reg} + (AW+1)'(2) <= (AW+1)'(count_reg)))
        else $error("segment search left the valid knots");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AP_WN) |=> (count_reg == $past(count_reg) + CW'(1))
                                   || (head_reg != $past(head_reg)))
        else $error("append neither grew the ring nor advanced the head");

    a_result_keeps_mult_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_SAT) |-> ($past(mstep_reg) == 3'd7) && $past(mphase_reg))
        else $error("query result taken before the last multiply");

endmodule

/* tb/tb_clamped_walk_hermite_interpolator_top.sv */
// tb_clamped_walk_hermite_interpolator_top: self-checking bench for the hermite interpolator
// depends on cwh_pkg and clamped_walk_hermite_interpolator_top; drives words, predicts results
`timescale 1ns / 1ps

module tb_clamped_walk_hermite_interpolator_top;
    import cwh_pkg::*;

    localparam int  RANDOM_WORDS = 1090;
    localparam longint CYCLE_LIMIT = 1200000;
    localparam int  KD = 16;
    localparam int  PEND_DEPTH = 2048;
    localparam longint ONE = 65536;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] value;
        status_t            st;
        logic               more;
        logic               known;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_VALUE_MIN;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] op = OP_NONE;
    logic signed [31:0] start_value = '0;
    logic [30:0] time_step = '0;
    logic signed [31:0] value_change = '0;
    logic signed [31:0] query_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] result_value;
    logic [1:0] status;
    logic needs_more;

    clamped_walk_hermite_interpolator_top dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted knot ring and clamps
    longint ring_t[KD];
    longint ring_v[KD];
    longint ring_s[KD];
    int head_pos;
    int held;
    longint clamp_lo;
    longint clamp_hi;

    // expected results in order, written by the sender and read by the monitor
    outcome_t pending_results[PEND_DEPTH];
    int pend_wr = 0;
    int pend_rd = 0;
    int mismatch_count = 0;
    longint cycle_count = 0;
    bit quiet_idle = 1'b0;

    function automatic int at(int k);
        return (head_pos + k) % KD;
    endfunction

    function automatic longint clip32(longint x);
        if (x > S32MAX) return S32MAX;
        if (x < S32MIN) return S32MIN;
        return x;
    endfunction

    function automatic longint half_slope(longint dv, longint dt);
        if (dt <= 0) return 0;
        return (dv * ONE) / (2 * dt);
    endfunction

    function automatic outcome_t interpolate(op_t o, logic signed [31:0] sv, logic [30:0] ts,
                                             logic signed [31:0] vc, logic signed [31:0] qt);
        outcome_t r;
        longint t0, t1, v0, v1, nt, nv, q, dt, u, u2, u3, h00, h10, h01, h11, acc;
        int a, b, i, w;
        r = '{value: '0, st: ST_OK, more: 1'b0, known: 1'b0};
        case (o)
            OP_START:
            begin
                head_pos = 0;
                held = 2;
                ring_t[0] = -ONE;
                ring_t[1] = -ONE / 2;
                ring_v[0] = sv;
                ring_v[1] = sv;
                ring_s[0] = 0;
                ring_s[1] = 0;
            end
            OP_APPEND:
            begin
                if (held < 2) r.st = ST_NOT_STARTED;
                else
                begin
                    a = at(held - 2);
                    b = at(held - 1);
                    t0 = ring_t[a];
                    t1 = ring_t[b];
                    v0 = ring_v[a];
                    v1 = ring_v[b];
                    nt = t1 + longint'(ts);
                    if (ts == 0 || nt > S32MAX) r.st = ST_BAD_STEP;
                    else
                    begin
                        nv = v1 + longint'(vc);
                        if (nv > clamp_hi) nv = clamp_hi;
                        if (nv < clamp_lo) nv = clamp_lo;
                        ring_s[b] = clip32(half_slope(nv - v1, nt - t1)
                                           + half_slope(v1 - v0, t1 - t0));
                        if (held < KD)
                        begin
                            w = at(held);
                            held++;
                        end
                        else
                        begin
                            w = head_pos;
                            head_pos = (head_pos + 1) % KD;
                        end
                        ring_t[w] = nt;
                        ring_v[w] = nv;
                        ring_s[w] = 0;
                    end
                end
            end
            OP_QUERY:
            begin
                if (held < 2) r.st = ST_NOT_STARTED;
                else
                begin
                    q = qt;
                    r.more = ring_t[at(held - 2)] < q;
                    if (!(ring_t[at(0)] < q && q < ring_t[at(held - 1)])) r.st = ST_RANGE;
                    else
                    begin
                        i = held - 2;
                        while (i > 0 && ring_t[at(i)] > q) i--;
                        a = at(i);
                        b = at(i + 1);
                        t0 = ring_t[a];
                        dt = ring_t[b] - t0;
                        if (dt <= 0) dt = 1;
                        u = ((q - t0) * ONE) / dt;
                        u2 = (u * u) / ONE;
                        u3 = (u2 * u) / ONE;
                        h00 = 2 * u3 - 3 * u2 + ONE;
                        h10 = u3 - 2 * u2 + u;
                        h01 = -2 * u3 + 3 * u2;
                        h11 = u3 - u2;
                        acc = (h00 * ring_v[a]) / ONE
                            + ((h10 * ring_s[a]) / ONE) * dt / ONE
                            + (h01 * ring_v[b]) / ONE
                            + ((h11 * ring_s[b]) / ONE) * dt / ONE;
                        r.value = 32'(clip32(acc));
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_VALUE_MIN) clamp_lo = $signed(data);
        else clamp_hi = $signed(data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pend_wr != pend_rd) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // one word; expected fields typed in are checked instead of the prediction
    task automatic send_word(op_t o, logic signed [31:0] sv, logic [30:0] ts,
                             logic signed [31:0] vc, logic signed [31:0] qt, outcome_t given);
        outcome_t r;
        @(negedge clk);
        while (!quiet_idle && $urandom_range(99) < 8) @(negedge clk);
        in_valid <= 1'b1;
        op <= o;
        start_value <= sv;
        time_step <= ts;
        value_change <= vc;
        query_time <= qt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = interpolate(o, sv, ts, vc, qt);
        if (given.known) r = given;
        pending_results[pend_wr % PEND_DEPTH] = r;
        pend_wr++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        out_stall <= !quiet_idle && ($urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin
        outcome_t e;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pend_wr == pend_rd)
            begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected word: %0d %0d %0d",
                                                   result_value, status, needs_more);
            end
            else
            begin
                e = pending_results[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (result_value !== e.value || status !== e.st || needs_more !== e.more)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 e.value, e.st, e.more, result_value, status, needs_more);
                end
            end
        end
    end

    typedef struct {
        op_t o;
        logic signed [31:0] sv;
        logic [30:0] ts;
        logic signed [31:0] vc;
        logic signed [31:0] qt;
        outcome_t given;
    } row_t;

    localparam outcome_t PREDICT = '{value: '0, st: ST_OK, more: 1'b0, known: 1'b0};
    localparam outcome_t NOT_RUNNING = '{value: '0, st: ST_NOT_STARTED, more: 1'b0,
                                         known: 1'b1};
    localparam outcome_t STEP_REJECT = '{value: '0, st: ST_BAD_STEP, more: 1'b0, known: 1'b1};
    localparam outcome_t PLAIN_OK = '{value: '0, st: ST_OK, more: 1'b0, known: 1'b1};

    row_t directed[] = '{
        '{OP_QUERY, 0, 0, 0, 0, NOT_RUNNING},
        '{OP_APPEND, 0, 1, 5, 0, NOT_RUNNING},
        '{OP_NONE, -1, '1, -1, -1, PLAIN_OK},
        '{OP_START, 32'sh8000_0000, 0, 0, 0, PLAIN_OK},
        '{OP_START, 32'sh0000_8000, 0, 0, 0, PLAIN_OK},
        '{OP_APPEND, 0, 0, 100, 0, STEP_REJECT},
        '{OP_APPEND, 0, 31'h0001_0000, 32'sh7FFF_FFFF, 0, PREDICT},
        '{OP_APPEND, 0, 31'h0000_8000, 32'sh8000_0000, 0, PREDICT},
        '{OP_APPEND, 0, 1, 32'sh0000_4000, 0, PREDICT},
        '{OP_QUERY, 0, 0, 0, -32'sd40000, PREDICT},
        '{OP_QUERY, 0, 0, 0, 32'sh0000_4000, PREDICT},
        '{OP_QUERY, 0, 0, 0, 32'sh8000_0000, PREDICT},
        '{OP_QUERY, 0, 0, 0, 32'sh7FFF_FFFF, PREDICT},
        '{OP_QUERY, 0, 0, 0, -32'sd65536, PREDICT},
        '{OP_APPEND, 0, 31'h7FFF_FFFF, 0, 0, STEP_REJECT},
        '{OP_APPEND, 0, 31'h7FFE_0000, 32'sd30000, 0, PREDICT},
        '{OP_QUERY, 0, 0, 0, 32'sh4000_0000, PREDICT},
        '{OP_APPEND, 0, 31'h0001_0000, 0, 0, STEP_REJECT},
        '{OP_START, 32'sh7FFF_FFFF, 0, 0, 0, PLAIN_OK},
        '{OP_QUERY, 0, 0, 0, -32'sd50000, PREDICT}
    };

    initial
    begin
        int n;
        op_t o;
        longint lo, hi;
        clamp_lo = 0;
        clamp_hi = ONE;
        head_pos = 0;
        held = 0;
        foreach (ring_t[k])
        begin
            ring_t[k] = 0;
            ring_v[k] = 0;
            ring_s[k] = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
            send_word(directed[k].o, directed[k].sv, directed[k].ts, directed[k].vc,
                      directed[k].qt, directed[k].given);
        // ring wrap with the default clamps
        for (int k = 0; k < 20; k++) send_word(OP_APPEND, 0, 31'h8000, 32'sd20000, 0, PREDICT);
        send_word(OP_QUERY, 0, 0, 0, 32'sh0005_0000, PREDICT);
        drain();

        n = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin lo = -ONE; hi = 2 * ONE; end
                1: begin lo = S32MIN; hi = S32MAX; end
                2: begin lo = ONE; hi = -ONE; end
                default: begin lo = $signed($urandom()) >>> 8; hi = lo + $urandom_range(1 << 20); end
            endcase
            write_reg(CFG_VALUE_MIN, 32'(lo));
            write_reg(CFG_VALUE_MAX, 32'(hi));
            quiet_idle = (phase == 1);
            send_word(OP_START, $urandom(), 0, 0, 0, PREDICT);
            while (n < (phase + 1) * RANDOM_WORDS / 4)
            begin
                logic [30:0] ts;
                logic signed [31:0] qt;
                int r;
                r = $urandom_range(99);
                ts = ($urandom_range(9) == 0) ? 31'($urandom()) : 31'($urandom_range(1 << 18));
                if ($urandom_range(49) == 0) ts = 0;
                qt = $signed(ring_t[at(0)]) + $signed($urandom_range(32'h3_0000));
                if (held >= 2 && $urandom_range(3) != 0)
                    qt = ring_t[at(0)] + (ring_t[at(held - 1)] - ring_t[at(0)])
                         * $urandom_range(1000) / 1000;
                if ($urandom_range(19) == 0) qt = $urandom();
                if (r < 3) o = OP_START;
                else if (r < 5) o = OP_NONE;
                else if (r < 50) o = OP_APPEND;
                else o = OP_QUERY;
                send_word(o, $urandom(), ts,
                          ($urandom_range(4) == 0) ? $signed($urandom())
                                                   : $signed($urandom_range(1 << 18)) - (1 << 17),
                          qt, PREDICT);
                if (o != OP_NONE) n++;
            end
            drain();
        end

        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
